/* src/csup_pkg.sv */
`default_nettype none
package csup_pkg;

  // configuration register indexes
  localparam logic [2:0] RegUsbThr  = 3'd0;
  localparam logic [2:0] RegFastThr = 3'd1;
  localparam logic [2:0] RegTempMin = 3'd2;
  localparam logic [2:0] RegTempMax = 3'd3;
  localparam logic [2:0] RegTempHys = 3'd4;
  localparam logic [2:0] RegBatEmpt = 3'd5;
  localparam logic [2:0] RegBatFull = 3'd6;

  localparam int unsigned SampleW  = 12;
  localparam int unsigned MvW      = 13;
  localparam int unsigned LevelW   = 11;
  localparam int unsigned FracBits = 10;
  localparam int unsigned CodeW    = 5;

  localparam logic [LevelW-1:0] LevelFull = LevelW'(1024);
  localparam logic [CodeW-1:0]  LimitFast = 5'd8;
  localparam logic [CodeW-1:0]  LimitSlow = 5'd4;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StPrep,
    StDiv,
    StDone
  } sup_state_e;

  // window control from the sequencer
  typedef struct packed {
    logic load;
    logic scan;
  } win_ctrl_t;

endpackage
`default_nettype wire

/* src/charger_supervisor_step.sv */
`default_nettype none
// a request passes the window scan, the prep state and, when the level needs it, the 10-step divider,
// then waits in the done state until the output register is free; a new request is taken only once
// the sequencer is back in idle
// the next request is taken while a finished result still waits on the output register
// reset: windows zero, slot zero, charge allowed set, previous usb/charging flags clear,
// configuration registers at their default thresholds
module charger_supervisor_step import csup_pkg::*; #(
  parameter int unsigned WINDOW_LEN = 3
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [12:0] cfg_data_i,
  // poll request
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // cc1_mv[11:0], cc2_mv[23:12], bat_half_mv[35:24], temp_valid[36], temperature[48:37],
  // input_limit_code[53:49], charge_enable_bit[54], charge_status[56:55], zero fill
  input  wire logic [63:0] s_axis_tdata_i,
  // result
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // bat_mv[12:0], level_frac[23:13], usb_present[24], fast_capable[25], is_charging[26],
  // write_charge_enable[27], charge_enable_value[28], write_input_limit[29],
  // input_limit_value[34:30], state_changed[35], zero fill
  output logic [39:0]      m_axis_tdata_o
);

  // configuration registers
  logic        [SampleW-1:0] usb_thr_q, fast_thr_q;
  logic signed [SampleW-1:0] temp_min_q, temp_max_q;
  logic        [7:0]         temp_hyst_q;
  logic        [MvW-1:0]     bat_empty_q, bat_full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usb_thr_q   <= 12'd10;
      fast_thr_q  <= 12'd700;
      temp_min_q  <= 12'sd160;
      temp_max_q  <= 12'sd720;
      temp_hyst_q <= 8'd32;
      bat_empty_q <= 13'd3200;
      bat_full_q  <= 13'd4000;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegUsbThr:  usb_thr_q   <= cfg_data_i[11:0];
        RegFastThr: fast_thr_q  <= cfg_data_i[11:0];
        RegTempMin: temp_min_q  <= $signed(cfg_data_i[11:0]);
        RegTempMax: temp_max_q  <= $signed(cfg_data_i[11:0]);
        RegTempHys: temp_hyst_q <= cfg_data_i[7:0];
        RegBatEmpt: bat_empty_q <= cfg_data_i;
        RegBatFull: bat_full_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  sup_state_e state_q, state_d;
  win_ctrl_t  win_ctrl;
  logic       accept, win_last, div_start, div_busy, need_div, out_free;

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_axis_tvalid_o || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    win_ctrl.load   = 1'b0;
    win_ctrl.scan   = 1'b0;
    div_start       = 1'b0;
    case (state_q)
      StIdle: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          win_ctrl.load = 1'b1;
          state_d       = StScan;
        end
      end
      StScan: begin
        win_ctrl.scan = 1'b1;
        if (win_last) state_d = StPrep;
      end
      StPrep: begin
        div_start = need_div;
        state_d   = need_div ? StDiv : StDone;
      end
      StDiv: begin
        if (!div_busy) state_d = StDone;
      end
      StDone: begin
        if (out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // latched request fields
  logic                      tv_q, en_bit_q;
  logic signed [SampleW-1:0] temp_q;
  logic        [CodeW-1:0]   code_q;
  logic        [1:0]         status_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tv_q     <= s_axis_tdata_i[36];
      temp_q   <= $signed(s_axis_tdata_i[48:37]);
      code_q   <= s_axis_tdata_i[53:49];
      en_bit_q <= s_axis_tdata_i[54];
      status_q <= s_axis_tdata_i[56:55];
    end
  end

  logic [SampleW-1:0] cc1_max, cc2_max, bat_max;

  csup_window #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_window (
    .clk_i,
    .rst_ni,
    .ctrl_i    (win_ctrl),
    .cc1_i     (s_axis_tdata_i[11:0]),
    .cc2_i     (s_axis_tdata_i[23:12]),
    .bat_i     (s_axis_tdata_i[35:24]),
    .last_o    (win_last),
    .cc1_max_o (cc1_max),
    .cc2_max_o (cc2_max),
    .bat_max_o (bat_max)
  );

  // level mapping setup, from the battery window maximum and the empty/full thresholds
  logic        [MvW-1:0] bat_mv;
  logic signed [MvW:0]   num_raw, den_raw, num_s, den_s;
  logic        [LevelW-1:0] level_fix;

  assign bat_mv  = {bat_max, 1'b0};
  assign num_raw = $signed({1'b0, bat_mv}) - $signed({1'b0, bat_empty_q});
  assign den_raw = $signed({1'b0, bat_full_q}) - $signed({1'b0, bat_empty_q});

  always_comb begin
    // reversed map when full sits below empty
    num_s = den_raw[MvW] ? -num_raw : num_raw;
    den_s = den_raw[MvW] ? -den_raw : den_raw;
    need_div  = 1'b0;
    level_fix = '0;
    if (den_raw == '0) begin
      level_fix = (bat_mv >= bat_full_q) ? LevelFull : '0;
    end else if (num_s <= 0) begin
      level_fix = '0;
    end else if (num_s >= den_s) begin
      level_fix = LevelFull;
    end else begin
      need_div = 1'b1;
    end
  end

  logic [FracBits-1:0] quot;

  csup_divider u_divider (
    .clk_i,
    .rst_ni,
    .start_i (div_start),
    .num_i   (num_s[MvW-1:0]),
    .den_i   (den_s[MvW-1:0]),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  // flags and temperature hysteresis
  logic              usb, fast, charging, fast_now, changed;
  logic signed [MvW-1:0] band_lo, band_hi, t_ext;
  logic              allowed_d;
  logic              allowed_q, prev_usb_q, prev_chg_q;

  assign usb      = (cc1_max > usb_thr_q) || (cc2_max > usb_thr_q);
  assign fast     = (cc1_max > fast_thr_q) || (cc2_max > fast_thr_q);
  assign charging = (status_q != 2'd0);
  assign fast_now = (code_q > LimitSlow);
  assign changed  = (usb != prev_usb_q) || (charging != prev_chg_q);
  assign t_ext    = MvW'(temp_q);
  assign band_lo  = MvW'(temp_min_q) + $signed({5'd0, temp_hyst_q});
  assign band_hi  = MvW'(temp_max_q) - $signed({5'd0, temp_hyst_q});

  always_comb begin
    allowed_d = allowed_q;
    if (tv_q) begin
      if ((temp_q < temp_min_q) || (temp_q > temp_max_q)) allowed_d = 1'b0;
      else if ((t_ext > band_lo) && (t_ext < band_hi))    allowed_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allowed_q  <= 1'b1;
      prev_usb_q <= 1'b0;
      prev_chg_q <= 1'b0;
    end else if (state_q == StPrep) begin
      allowed_q  <= allowed_d;
      prev_usb_q <= usb;
      prev_chg_q <= charging;
    end
  end

  // result under assembly
  logic [MvW-1:0]    res_bat_q;
  logic [LevelW-1:0] res_level_q;
  logic [CodeW-1:0]  res_limit_q;
  logic              res_usb_q, res_fast_q, res_chg_q, res_wce_q, res_cev_q;
  logic              res_wil_q, res_chgd_q;

  always_ff @(posedge clk_i) begin
    if (state_q == StPrep) begin
      res_bat_q   <= bat_mv;
      res_level_q <= level_fix;
      res_usb_q   <= usb;
      res_fast_q  <= fast;
      res_chg_q   <= charging;
      res_wce_q   <= (allowed_d != en_bit_q);
      res_cev_q   <= allowed_d;
      res_wil_q   <= charging && (fast != fast_now);
      res_limit_q <= fast ? LimitFast : LimitSlow;
      res_chgd_q  <= changed;
    end else if ((state_q == StDiv) && !div_busy) begin
      res_level_q <= LevelW'(quot);
    end
  end

  // output register
  logic        out_valid_q;
  logic [39:0] out_data_q;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == StDone) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == StDone) && out_free) begin
      out_data_q <= {4'd0, res_chgd_q, res_limit_q, res_wil_q, res_cev_q, res_wce_q,
                     res_chg_q, res_fast_q, res_usb_q, res_level_q, res_bat_q};
    end
  end

endmodule
`default_nettype wire

/* src/csup_window.sv */
`default_nettype none
module csup_window import csup_pkg::*; #(
  parameter int unsigned WINDOW_LEN = 3
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire win_ctrl_t          ctrl_i,
  input  wire logic [SampleW-1:0] cc1_i,
  input  wire logic [SampleW-1:0] cc2_i,
  input  wire logic [SampleW-1:0] bat_i,
  output logic                    last_o,
  output logic      [SampleW-1:0] cc1_max_o,
  output logic      [SampleW-1:0] cc2_max_o,
  output logic      [SampleW-1:0] bat_max_o
);

  localparam int unsigned IdxW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(WINDOW_LEN - 1);

  logic [SampleW-1:0] cc1_q [WINDOW_LEN];
  logic [SampleW-1:0] cc2_q [WINDOW_LEN];
  logic [SampleW-1:0] bat_q [WINDOW_LEN];
  logic [IdxW-1:0]    slot_q, idx_q;
  logic [SampleW-1:0] cc1_max_q, cc2_max_q, bat_max_q;

  assign last_o    = (idx_q == IdxLast);
  assign cc1_max_o = cc1_max_q;
  assign cc2_max_o = cc2_max_q;
  assign bat_max_o = bat_max_q;

  // sample store, cleared to zero by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        cc1_q[i] <= '0;
        cc2_q[i] <= '0;
        bat_q[i] <= '0;
      end
      slot_q <= '0;
    end else if (ctrl_i.load) begin
      cc1_q[slot_q] <= cc1_i;
      cc2_q[slot_q] <= cc2_i;
      bat_q[slot_q] <= bat_i;
      slot_q <= (slot_q == IdxLast) ? '0 : slot_q + 1'b1;
    end
  end

  // one entry per cycle through the compare unit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (ctrl_i.load) begin
      idx_q <= '0;
    end else if (ctrl_i.scan) begin
      idx_q <= last_o ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cc1_max_q <= '0;
      cc2_max_q <= '0;
      bat_max_q <= '0;
    end else if (ctrl_i.scan) begin
      if (cc1_q[idx_q] > cc1_max_q) cc1_max_q <= cc1_q[idx_q];
      if (cc2_q[idx_q] > cc2_max_q) cc2_max_q <= cc2_q[idx_q];
      if (bat_q[idx_q] > bat_max_q) bat_max_q <= bat_q[idx_q];
    end
  end

endmodule
`default_nettype wire

/* src/csup_divider.sv */
`default_nettype none
module csup_divider import csup_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [MvW-1:0]      num_i,
  input  wire logic [MvW-1:0]      den_i,
  output logic                     busy_o,
  output logic     [FracBits-1:0]  quot_o
);

  // restoring fraction divider, num below den, one quotient bit a cycle
  localparam int unsigned CntW = $clog2(FracBits);
  localparam logic [CntW-1:0] CntLast = CntW'(FracBits - 1);

  logic                busy_q;
  logic [CntW-1:0]     cnt_q;
  logic [MvW-1:0]      rem_q, den_q;
  logic [FracBits-1:0] quot_q;
  logic [MvW:0]        rem2;
  logic                take;

  assign rem2   = {rem_q, 1'b0};
  assign take   = (rem2 >= {1'b0, den_q});
  assign busy_o = busy_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntLast) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= take ? MvW'(rem2 - {1'b0, den_q}) : rem2[MvW-1:0];
      quot_q <= {quot_q[FracBits-2:0], take};
    end
  end

endmodule
`default_nettype wire
